// ----- rtl/core/idl_pkg.sv -----
// Shared types and constants for the indexed doubly linked list block.
`default_nettype none

package idl_pkg;

    localparam int IDX_W    = 7;
    localparam int VAL_IN_W = 32;

    typedef logic [1:0] t_status;

    localparam t_status ST_OK      = 2'd0;
    localparam t_status ST_INVALID = 2'd1;
    localparam t_status ST_FULL    = 2'd2;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DROP   = 1'b1;

    typedef struct packed {
        logic load;
        logic exec;
        logic link;
        logic put;
    } t_cmd;

    typedef struct packed {
        logic ok;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

// ----- rtl/core/idl_datapath.sv -----
// Datapath: node memories, free chain, high-water mark and result register.
`default_nettype none

module idl_datapath import idl_pkg::*; #(
    parameter int CAPACITY    = 128,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_op,
    input  wire logic [IDX_W-1:0]    i_node_index,
    input  wire logic [VAL_IN_W-1:0] i_value,
    input  wire logic                i_ready,
    input  wire t_cmd                i_cmd,
    output t_sts                     o_sts,
    output logic                     o_valid,
    output t_status                  o_status,
    output logic [IDX_W-1:0]         o_new_index
);

    localparam int IW = $clog2(CAPACITY);
    localparam int HW = $clog2(CAPACITY + 1);
    localparam int CW = (HW > IDX_W) ? HW : IDX_W;

    logic [IW-1:0]          mem_next    [CAPACITY];
    logic [IW-1:0]          mem_prev    [CAPACITY];
    logic                   mem_mark    [CAPACITY];
    logic [VALUE_WIDTH-1:0] mem_payload [CAPACITY];

    logic                   r_op;
    logic [IDX_W-1:0]       r_idx;
    logic [VALUE_WIDTH-1:0] r_val;
    logic [IW-1:0]          r_rd_next;
    logic [IW-1:0]          r_rd_next_fh;
    logic [IW-1:0]          r_rd_prev;
    logic                   r_rd_mark;
    logic [IW-1:0]          r_free_head;
    logic [HW-1:0]          r_high_water;
    logic                   r_root_ok;
    logic [IW-1:0]          r_b_addr;
    logic [IW-1:0]          r_b_data;
    logic [IW-1:0]          r_c_addr;
    logic [IW-1:0]          r_c_data;
    t_status                r_res_status;
    logic [IDX_W-1:0]       r_res_index;
    logic                   r_out_valid;
    t_status                r_out_status;
    logic [IDX_W-1:0]       r_out_index;

    logic [CW-1:0]                  w_in_ext;
    logic [IW-1:0]                  w_in_addr;
    logic [CW-1:0]                  w_idx_ext;
    logic [IW-1:0]                  w_idx_addr;
    logic [CW-1:0]                  w_hw_ext;
    logic [VAL_IN_W+VALUE_WIDTH-1:0] w_val_ext;
    logic                           w_root;
    logic [IW-1:0]                  w_succ;
    logic [IW-1:0]                  w_pred;
    logic                           w_in_use;
    logic                           w_fh_empty;
    logic                           w_full;
    logic [IW-1:0]                  w_fresh;
    logic [IW+IDX_W-1:0]            w_fresh_ext;
    t_status                        w_status;
    logic                           w_ok;
    logic                           w_insert;
    logic                           w_a_we;
    logic [IW-1:0]                  w_a_addr;
    logic [IW-1:0]                  w_a_next;
    logic [IW-1:0]                  w_a_prev;

    assign w_in_ext    = CW'(i_node_index);
    assign w_in_addr   = w_in_ext[IW-1:0];
    assign w_idx_ext   = CW'(r_idx);
    assign w_idx_addr  = w_idx_ext[IW-1:0];
    assign w_hw_ext    = CW'(r_high_water);
    assign w_val_ext   = {{VALUE_WIDTH{1'b0}}, i_value};
    assign w_root      = (r_idx == '0);
    assign w_succ      = (w_root && !r_root_ok) ? '0 : r_rd_next;
    assign w_pred      = (w_root && !r_root_ok) ? '0 : r_rd_prev;
    assign w_in_use    = (w_idx_ext < w_hw_ext) && (w_root || !r_rd_mark);
    assign w_fh_empty  = (r_free_head == '0);
    assign w_full      = w_fh_empty && (w_hw_ext == CW'(CAPACITY));
    assign w_fresh     = w_fh_empty ? r_high_water[IW-1:0] : r_free_head;
    assign w_fresh_ext = {{IDX_W{1'b0}}, w_fresh};
    assign w_insert    = (r_op == OP_INSERT);

    always_comb begin
        if (w_insert) begin
            if (!w_in_use) begin
                w_status = ST_INVALID;
            end else if (w_full) begin
                w_status = ST_FULL;
            end else begin
                w_status = ST_OK;
            end
        end else begin
            if (w_root || !w_in_use) begin
                w_status = ST_INVALID;
            end else begin
                w_status = ST_OK;
            end
        end
    end

    assign w_ok     = (w_status == ST_OK);
    assign w_a_we   = i_cmd.exec && w_ok;
    assign w_a_addr = w_insert ? w_fresh : w_idx_addr;
    assign w_a_next = w_insert ? w_succ : r_free_head;
    assign w_a_prev = w_insert ? w_idx_addr : '0;

    always_ff @(posedge i_clk) begin
        if (w_a_we) begin
            mem_next[w_a_addr] <= w_a_next;
        end else if (i_cmd.link) begin
            mem_next[r_b_addr] <= r_b_data;
        end
        if (i_cmd.load) begin
            r_rd_next    <= mem_next[w_in_addr];
            r_rd_next_fh <= mem_next[r_free_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_we) begin
            mem_prev[w_a_addr] <= w_a_prev;
        end else if (i_cmd.link) begin
            mem_prev[r_c_addr] <= r_c_data;
        end
        if (i_cmd.load) begin
            r_rd_prev <= mem_prev[w_in_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_we) begin
            mem_mark[w_a_addr] <= !w_insert;
        end
        if (i_cmd.load) begin
            r_rd_mark <= mem_mark[w_in_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_we && w_insert) begin
            mem_payload[w_a_addr] <= r_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_head  <= '0;
            r_high_water <= HW'(1);
            r_root_ok    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_a_we) begin
                if (w_insert) begin
                    r_free_head  <= w_fh_empty ? r_free_head : r_rd_next_fh;
                    r_high_water <= r_high_water + HW'(w_fh_empty);
                end else begin
                    r_free_head <= w_idx_addr;
                end
            end
            if (i_cmd.link) begin
                r_root_ok <= 1'b1;
            end
            if (i_cmd.put) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_op;
            r_idx <= i_node_index;
            r_val <= w_val_ext[VALUE_WIDTH-1:0];
        end
        if (i_cmd.exec) begin
            r_res_status <= w_status;
            r_res_index  <= (w_ok && w_insert) ? w_fresh_ext[IDX_W-1:0] : '0;
            if (w_insert) begin
                r_b_addr <= w_idx_addr;
                r_b_data <= w_fresh;
                r_c_addr <= w_succ;
                r_c_data <= w_fresh;
            end else begin
                r_b_addr <= w_pred;
                r_b_data <= w_succ;
                r_c_addr <= w_succ;
                r_c_data <= w_pred;
            end
        end
        if (i_cmd.put) begin
            r_out_status <= r_res_status;
            r_out_index  <= r_res_index;
        end
    end

    assign o_sts.ok       = w_ok;
    assign o_sts.out_free = !r_out_valid || i_ready;
    assign o_valid        = r_out_valid;
    assign o_status       = r_out_status;
    assign o_new_index    = r_out_index;

endmodule

`default_nettype wire

// ----- rtl/core/idl_ctrl.sv -----
// Controller: sequences read, first write, link write and result hand-off.
`default_nettype none

module idl_ctrl import idl_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  wire t_sts i_sts,
    output logic      o_ready,
    output t_cmd      o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_LINK = 4'b0100,
        S_PUT  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.load = i_valid;
                if (i_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_sts.ok ? S_LINK : S_PUT;
            end
            S_LINK: begin
                o_cmd.link = 1'b1;
                n_state    = S_PUT;
            end
            S_PUT: begin
                if (i_sts.out_free) begin
                    o_cmd.put = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_ready = (r_state == S_IDLE);

endmodule

`default_nettype wire

// ----- rtl/core/indexed_doubly_linked_list.sv -----
// Top level of the indexed doubly linked list block.
//
// Input channel (i_valid / o_ready) carries one item: i_op selects insert
// after i_node_index or drop of i_node_index; i_value is the payload stored
// in a new node. Output channel (o_valid / i_ready) returns one item per
// input item: o_status (ok, invalid node, store full) and o_new_index.
// Node 0 is the root of a circular list; freed nodes are reused first,
// then nodes above the high-water mark.
// One item is in work at a time: no new item is taken until the result
// of the last one is handed off. Each link memory has a single write
// port, so after the read the node itself and its neighbors are written
// in separate steps before hand-off; an invalid or full item writes no node.
// Reset empties the list and the free chain at once; no clearing pass.
// A stalled receiver holds the result in the output register; the next
// item is still taken and worked on, and waits only for hand-off.
`default_nettype none

module indexed_doubly_linked_list import idl_pkg::*; #(
    parameter int CAPACITY    = 128,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic                i_op,
    input  wire logic [IDX_W-1:0]    i_node_index,
    input  wire logic [VAL_IN_W-1:0] i_value,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output t_status                  o_status,
    output logic [IDX_W-1:0]         o_new_index
);

    t_cmd w_cmd;
    t_sts w_sts;

    idl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (w_sts),
        .o_ready (o_ready),
        .o_cmd   (w_cmd)
    );

    idl_datapath #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op         (i_op),
        .i_node_index (i_node_index),
        .i_value      (i_value),
        .i_ready      (i_ready),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .o_valid      (o_valid),
        .o_status     (o_status),
        .o_new_index  (o_new_index)
    );

endmodule

`default_nettype wire

// ----- rtl/core/idl_checker.sv -----
// Port-level checker for the indexed doubly linked list block and its bind.
`default_nettype none

module idl_checker import idl_pkg::*; (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_valid,
    input wire logic             o_ready,
    input wire logic             o_valid,
    input wire logic             i_ready,
    input wire logic [1:0]       o_status,
    input wire logic [IDX_W-1:0] o_new_index
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result item dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_status) && $stable(o_new_index))
        else $error("stalled result item changed");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("second item taken while one is in work");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ST_OK || o_status == ST_INVALID ||
                     o_status == ST_FULL))
        else $error("unknown status code");

    a_reject_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_new_index == '0)
        else $error("rejected item carries a node index");

endmodule

bind indexed_doubly_linked_list idl_checker u_idl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_ready     (o_ready),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_status    (o_status),
    .o_new_index (o_new_index)
);

`default_nettype wire

// ----- verif/indexed_doubly_linked_list_test.sv -----
// Testbench for the indexed doubly linked list: random handshakes, link predictor, result checks.
`timescale 1ns / 1ps

module indexed_doubly_linked_list_test;
    import idl_pkg::*;

    localparam int NODES       = 128;
    localparam int ITEM_COUNT  = 1350;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        t_status          status;
        logic [IDX_W-1:0] index;
    } t_reply;

    class link_tracker;
        logic [IDX_W-1:0] succ_of[NODES];
        logic [IDX_W-1:0] pred_of[NODES];
        bit               on_free[NODES];
        logic [IDX_W-1:0] free_top;
        int               water;
        t_reply           due[$];
        int               errors;

        function new();
            foreach (on_free[n]) begin
                on_free[n] = 1'b0;
            end
            succ_of[0] = '0;
            pred_of[0] = '0;
            free_top   = '0;
            water      = 1;
            errors     = 0;
        endfunction

        function bit live(int n);
            return n < water && (n == 0 || !on_free[n]);
        endfunction

        function void note_op(logic op, logic [IDX_W-1:0] n);
            t_reply           r;
            logic [IDX_W-1:0] fresh;
            logic [IDX_W-1:0] p;
            logic [IDX_W-1:0] s;
            r.status = ST_OK;
            r.index  = '0;
            if (op == OP_INSERT) begin
                if (!live(n)) begin
                    r.status = ST_INVALID;
                end else if (free_top == 0 && water >= NODES) begin
                    r.status = ST_FULL;
                end else begin
                    if (free_top != 0) begin
                        fresh          = free_top;
                        free_top       = succ_of[fresh];
                        on_free[fresh] = 1'b0;
                    end else begin
                        fresh = IDX_W'(water);
                        water = water + 1;
                    end
                    s              = succ_of[n];
                    pred_of[fresh] = n;
                    succ_of[fresh] = s;
                    succ_of[n]     = fresh;
                    pred_of[s]     = fresh;
                    r.index        = fresh;
                end
            end else begin
                if (n == 0 || !live(n)) begin
                    r.status = ST_INVALID;
                end else begin
                    p          = pred_of[n];
                    s          = succ_of[n];
                    succ_of[p] = s;
                    pred_of[s] = p;
                    succ_of[n] = free_top;
                    pred_of[n] = '0;
                    on_free[n] = 1'b1;
                    free_top   = n;
                end
            end
            due.push_back(r);
        endfunction

        function void check_reply(t_status st, logic [IDX_W-1:0] ix);
            t_reply r;
            if (due.size() == 0) begin
                $error("unexpected item: status %0d, new_index %0d", st, ix);
                errors++;
                return;
            end
            r = due.pop_front();
            if (st !== r.status) begin
                $error("status: expected %0d, actual %0d", r.status, st);
                errors++;
            end
            if (ix !== r.index) begin
                $error("new_index: expected %0d, actual %0d", r.index, ix);
                errors++;
            end
        endfunction

        function int pick_live(bit with_root);
            int pool[$];
            for (int n = (with_root ? 0 : 1); n < water; n++) begin
                if (live(n)) pool.push_back(n);
            end
            if (pool.size() == 0) return 0;
            return pool[$urandom_range(0, pool.size() - 1)];
        endfunction

        function int pick_freed();
            int pool[$];
            for (int n = 1; n < water; n++) begin
                if (on_free[n]) pool.push_back(n);
            end
            if (pool.size() == 0) return 0;
            return pool[$urandom_range(0, pool.size() - 1)];
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n      = 1'b0;
    logic                i_valid      = 1'b0;
    logic                o_ready;
    logic                i_op         = OP_INSERT;
    logic [IDX_W-1:0]    i_node_index = '0;
    logic [VAL_IN_W-1:0] i_value      = '0;
    logic                o_valid;
    logic                i_ready      = 1'b0;
    t_status             o_status;
    logic [IDX_W-1:0]    o_new_index;

    link_tracker tracker = new();
    int          issued  = 0;
    int          cycles  = 0;
    bit          src_steady = 1'b0;

    indexed_doubly_linked_list DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_op         (i_op),
        .i_node_index (i_node_index),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_status     (o_status),
        .o_new_index  (o_new_index)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL indexed_doubly_linked_list");
            $finish;
        end
    end

    task automatic push_item(logic op, logic [IDX_W-1:0] n, logic [VAL_IN_W-1:0] v);
        int gap;
        if ($urandom_range(0, 31) == 0) src_steady = !src_steady;
        gap = src_steady ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_op         <= op;
        i_node_index <= n;
        i_value      <= v;
        @(posedge i_clk);
        while (o_ready !== 1'b1) @(posedge i_clk);
        tracker.note_op(op, n);
        issued++;
    endtask

    task automatic push_noise();
        int pick;
        int n;
        pick = $urandom_range(0, 3);
        case (pick)
            0: begin
                push_item(1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)), $urandom());
            end
            1: begin
                n = tracker.pick_freed();
                push_item(1'($urandom_range(0, 1)), 7'(n), $urandom());
            end
            2: begin
                n = (tracker.water < NODES) ? $urandom_range(tracker.water, NODES - 1) : 127;
                push_item(1'($urandom_range(0, 1)), 7'(n), $urandom());
            end
            default: begin
                push_item(OP_DROP, '0, $urandom());
            end
        endcase
    endtask

    task automatic push_random(int insert_pct);
        int n;
        if ($urandom_range(0, 99) < 10) begin
            push_noise();
        end else if ($urandom_range(0, 99) < insert_pct) begin
            push_item(OP_INSERT, 7'(tracker.pick_live(1'b1)), $urandom());
        end else begin
            n = tracker.pick_live(1'b0);
            if (n == 0) begin
                push_item(OP_INSERT, '0, $urandom());
            end else begin
                push_item(OP_DROP, 7'(n), $urandom());
            end
        end
    endtask

    initial begin
        int gap;
        bit steady;
        steady = 1'b0;
        forever begin
            if ($urandom_range(0, 31) == 0) steady = !steady;
            gap = steady ? 0 : $urandom_range(0, 9);
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (o_valid !== 1'b1 || !i_rst_n) @(posedge i_clk);
            tracker.check_reply(o_status, o_new_index);
        end
    end

    initial begin
        int phase;
        int span;
        int bias;
        phase = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        push_item(OP_INSERT, 7'd0,   32'h7FFF_FFFF);
        push_item(OP_INSERT, 7'd0,   32'h8000_0000);
        push_item(OP_INSERT, 7'd1,   32'h0000_0000);
        push_item(OP_INSERT, 7'd3,   32'hFFFF_FFFF);
        push_item(OP_INSERT, 7'd127, 32'h1234_5678);
        push_item(OP_INSERT, 7'd5,   32'h0F0F_0F0F);
        push_item(OP_DROP,   7'd0,   32'h0000_0000);
        push_item(OP_DROP,   7'd127, 32'hFFFF_FFFF);
        push_item(OP_DROP,   7'd3,   32'h0000_0000);
        push_item(OP_DROP,   7'd3,   32'h0000_0000);
        push_item(OP_INSERT, 7'd3,   32'hDEAD_BEEF);
        push_item(OP_DROP,   7'd1,   32'h0000_0000);
        push_item(OP_INSERT, 7'd2,   32'h5555_5555);
        push_item(OP_INSERT, 7'd0,   32'hAAAA_AAAA);
        push_item(OP_INSERT, 7'd4,   32'h0000_0001);
        push_item(OP_DROP,   7'd5,   32'h0000_0000);
        push_item(OP_DROP,   7'd2,   32'h0000_0000);
        push_item(OP_DROP,   7'd4,   32'h0000_0000);
        push_item(OP_DROP,   7'd1,   32'h0000_0000);
        push_item(OP_DROP,   7'd3,   32'h0000_0000);
        push_item(OP_INSERT, 7'd0,   32'hFFFF_FFFE);
        push_item(OP_INSERT, 7'd5,   32'h8000_0001);

        while (issued < ITEM_COUNT) begin
            case (phase % 3)
                0: begin
                    bias = 85;
                    span = $urandom_range(200, 260);
                end
                1: begin
                    bias = 15;
                    span = $urandom_range(150, 220);
                end
                default: begin
                    bias = 50;
                    span = $urandom_range(100, 200);
                end
            endcase
            repeat (span) begin
                if (issued < ITEM_COUNT) push_random(bias);
            end
            phase++;
        end
        i_valid <= 1'b0;

        while (tracker.due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (tracker.errors == 0) begin
            $display("PASS indexed_doubly_linked_list");
        end else begin
            $display("FAIL indexed_doubly_linked_list");
        end
        $finish;
    end

endmodule
